// File: rtl/core/c_subset_lexer_core_macros.svh
// assertion macros shared by the lexer core modules
`ifndef C_SUBSET_LEXER_CORE_MACROS_SVH
`define C_SUBSET_LEXER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define CSL_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define CSL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/csl_pkg.sv
// shared types, constants and functions of the lexer core
package csl_pkg;

   localparam int LINE_BITS       = 16;
   localparam int COLUMN_BITS     = 12;
   localparam int KEYWORD_MAX_LEN = 8;
   localparam int KIND_BITS       = 6;
   localparam int CHAR_BITS       = 8;
   localparam int OP_BITS         = 4;

   // word buffer sizing: length counts one past the limit to flag long words
   localparam int WLEN_BITS = $clog2(KEYWORD_MAX_LEN + 2);
   localparam int WIDX_BITS = $clog2(KEYWORD_MAX_LEN);

   // queue sizing
   localparam int IQ_DEPTH      = 4;
   localparam int IQ_PTR_BITS   = $clog2(IQ_DEPTH);
   localparam int OUTQ_DEPTH    = 4;
   localparam int OUTQ_PTR_BITS = $clog2(OUTQ_DEPTH);

   // token kinds
   localparam logic [KIND_BITS-1:0] KIND_KEY0    = 6'd15;
   localparam logic [KIND_BITS-1:0] KIND_IDENT   = 6'd33;
   localparam logic [KIND_BITS-1:0] KIND_INT     = 6'd34;
   localparam logic [KIND_BITS-1:0] KIND_DOUBLE  = 6'd35;
   localparam logic [KIND_BITS-1:0] KIND_FLOAT   = 6'd36;
   localparam logic [KIND_BITS-1:0] KIND_STRING  = 6'd37;
   localparam logic [KIND_BITS-1:0] KIND_UNKNOWN = 6'd38;
   localparam logic [KIND_BITS-1:0] KIND_END     = 6'd39;

   // operator indexes, equal to their token kinds
   localparam int OP_COUNT = 15;
   localparam logic [OP_BITS-1:0] OP_PLUS   = 4'd0;
   localparam logic [OP_BITS-1:0] OP_MINUS  = 4'd1;
   localparam logic [OP_BITS-1:0] OP_STAR   = 4'd2;
   localparam logic [OP_BITS-1:0] OP_SLASH  = 4'd3;
   localparam logic [OP_BITS-1:0] OP_ASSIGN = 4'd4;
   localparam logic [OP_BITS-1:0] OP_LPAREN = 4'd5;
   localparam logic [OP_BITS-1:0] OP_RPAREN = 4'd6;
   localparam logic [OP_BITS-1:0] OP_LBRACE = 4'd7;
   localparam logic [OP_BITS-1:0] OP_RBRACE = 4'd8;
   localparam logic [OP_BITS-1:0] OP_LESS   = 4'd9;
   localparam logic [OP_BITS-1:0] OP_GREAT  = 4'd10;
   localparam logic [OP_BITS-1:0] OP_LBRACK = 4'd11;
   localparam logic [OP_BITS-1:0] OP_RBRACK = 4'd12;
   localparam logic [OP_BITS-1:0] OP_COMMA  = 4'd13;
   localparam logic [OP_BITS-1:0] OP_SEMI   = 4'd14;
   localparam logic [OP_BITS-1:0] OP_NONE   = 4'd15;

   // character codes
   localparam logic [CHAR_BITS-1:0] CH_TAB    = 8'h09;
   localparam logic [CHAR_BITS-1:0] CH_LF     = 8'h0A;
   localparam logic [CHAR_BITS-1:0] CH_CR     = 8'h0D;
   localparam logic [CHAR_BITS-1:0] CH_SPACE  = " ";
   localparam logic [CHAR_BITS-1:0] CH_QUOTE  = 8'h22;
   localparam logic [CHAR_BITS-1:0] CH_BSLASH = 8'h5C;
   localparam logic [CHAR_BITS-1:0] CH_DOT    = ".";
   localparam logic [CHAR_BITS-1:0] CH_UNDER  = "_";
   localparam logic [CHAR_BITS-1:0] CH_E      = "e";
   localparam logic [CHAR_BITS-1:0] CH_F      = "f";

   // keyword table, text right-justified, first letter most significant
   localparam int KW_COUNT     = 18;
   localparam int KW_TEXT_BITS = 64;
   localparam logic [KW_TEXT_BITS-1:0] KW_TEXT [KW_COUNT] = '{
      "char", "int", "double", "float", "struct", "enum", "void", "short",
      "long", "const", "static", "if", "else", "for", "while", "break",
      "continue", "return"};
   localparam int KW_LEN [KW_COUNT] = '{
      4, 3, 6, 5, 6, 4, 4, 5, 4, 5, 6, 2, 4, 3, 5, 5, 8, 6};

   typedef enum logic [3:0] {
      CC_LF,
      CC_CR,
      CC_SPACE,
      CC_DIGIT,
      CC_LETTER_E,
      CC_LETTER_F,
      CC_WORD,
      CC_DOT,
      CC_QUOTE,
      CC_BSLASH,
      CC_OP,
      CC_OTHER
   } char_class_type;

   // classified input item as it travels through the queue
   typedef struct packed {
      logic                 eot;
      char_class_type       cls;
      logic [OP_BITS-1:0]   op_idx;
      logic [CHAR_BITS-1:0] code;
   } item_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]   kind;
      logic [LINE_BITS-1:0]   line;
      logic [COLUMN_BITS-1:0] column;
      logic                   last;
   } token_type;

   // up to two tokens handed from the scanner to the output queue
   typedef struct packed {
      logic [1:0] count;
      token_type  tok0;
      token_type  tok1;
   } push_type;

   typedef logic [KEYWORD_MAX_LEN-1:0][CHAR_BITS-1:0] word_type;

   function automatic logic [OP_BITS-1:0] op_index(input logic [CHAR_BITS-1:0] c);
      logic [OP_BITS-1:0] idx;
      case (c)
         "+":     idx = OP_PLUS;
         "-":     idx = OP_MINUS;
         "*":     idx = OP_STAR;
         "/":     idx = OP_SLASH;
         "=":     idx = OP_ASSIGN;
         "(":     idx = OP_LPAREN;
         ")":     idx = OP_RPAREN;
         "{":     idx = OP_LBRACE;
         "}":     idx = OP_RBRACE;
         "<":     idx = OP_LESS;
         ">":     idx = OP_GREAT;
         "[":     idx = OP_LBRACK;
         "]":     idx = OP_RBRACK;
         ",":     idx = OP_COMMA;
         ";":     idx = OP_SEMI;
         default: idx = OP_NONE;
      endcase
      return idx;
   endfunction

   function automatic char_class_type classify(input logic [CHAR_BITS-1:0] c);
      char_class_type cls;
      if (c == CH_LF) begin
         cls = CC_LF;
      end else if (c == CH_CR) begin
         cls = CC_CR;
      end else if (c inside {CH_SPACE, [CH_TAB:CH_CR]}) begin
         cls = CC_SPACE;
      end else if (c inside {["0":"9"]}) begin
         cls = CC_DIGIT;
      end else if (c == CH_E) begin
         cls = CC_LETTER_E;
      end else if (c == CH_F) begin
         cls = CC_LETTER_F;
      end else if (c inside {["a":"z"], ["A":"Z"], CH_UNDER}) begin
         cls = CC_WORD;
      end else if (c == CH_DOT) begin
         cls = CC_DOT;
      end else if (c == CH_QUOTE) begin
         cls = CC_QUOTE;
      end else if (c == CH_BSLASH) begin
         cls = CC_BSLASH;
      end else if (op_index(c) != OP_NONE) begin
         cls = CC_OP;
      end else begin
         cls = CC_OTHER;
      end
      return cls;
   endfunction

   // keyword lookup over the buffered word, identifier when nothing matches
   function automatic logic [KIND_BITS-1:0] keyword_kind(input word_type chars,
                                                          input logic [WLEN_BITS-1:0] len);
      logic [KIND_BITS-1:0] kind;
      logic                 hit;
      kind = KIND_IDENT;
      for (int i = KW_COUNT - 1; i >= 0; i--) begin
         hit = (len == WLEN_BITS'(KW_LEN[i]));
         for (int j = 0; j < KEYWORD_MAX_LEN; j++) begin
            if (j < KW_LEN[i]) begin
               hit = hit && (chars[j] == KW_TEXT[i][(KW_LEN[i] - 1 - j) * CHAR_BITS +: CHAR_BITS]);
            end
         end
         if (hit) begin
            kind = KIND_KEY0 + KIND_BITS'(i);
         end
      end
      return kind;
   endfunction

endpackage

// File: rtl/core/csl_if.sv
// request and response channel interfaces of the lexer core
interface csl_req_if;
   logic                            valid;
   logic                            ready;
   logic                            command;
   logic [csl_pkg::CHAR_BITS-1:0]   char_code;

   modport source (output valid, command, char_code, input ready);
   modport sink (input valid, command, char_code, output ready);
endinterface

interface csl_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [csl_pkg::KIND_BITS-1:0]     token_kind;
   logic [csl_pkg::LINE_BITS-1:0]     token_line;
   logic [csl_pkg::COLUMN_BITS-1:0]   token_column;
   logic                              last_of_run;

   modport source (output valid, token_kind, token_line, token_column, last_of_run,
                   input ready);
   modport sink (input valid, token_kind, token_line, token_column, last_of_run,
                 output ready);
endinterface

// File: rtl/core/csl_front.sv
// front end: accepts request transfers and classifies each byte
module csl_front (
   csl_req_if.sink              req_if,
   input  logic                 q_full,
   output logic                 push_valid,
   output csl_pkg::item_type    push_item
);

   // accept whenever the item queue has room
   assign req_if.ready = !q_full;
   assign push_valid   = req_if.valid && !q_full;

   // character class and operator index for the back end
   always_comb begin
      push_item.eot    = req_if.command;
      push_item.cls    = csl_pkg::classify(req_if.char_code);
      push_item.op_idx = csl_pkg::op_index(req_if.char_code);
      push_item.code   = req_if.char_code;
   end

endmodule

// File: rtl/core/csl_queue.sv
// item queue between the front end and the scanner
module csl_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  csl_pkg::item_type    push_item,
   input  logic                 pop,
   output logic                 full,
   output logic                 empty,
   output csl_pkg::item_type    head
);

   csl_pkg::item_type                  mem [csl_pkg::IQ_DEPTH];
   logic [csl_pkg::IQ_PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [csl_pkg::IQ_PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [csl_pkg::IQ_PTR_BITS:0]      count_ff, count_in;

   assign full  = (count_ff == (csl_pkg::IQ_PTR_BITS + 1)'(csl_pkg::IQ_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + (csl_pkg::IQ_PTR_BITS)'(push_valid);
      rd_ptr_in = rd_ptr_ff + (csl_pkg::IQ_PTR_BITS)'(pop);
      count_in  = count_ff + (csl_pkg::IQ_PTR_BITS + 1)'(push_valid)
                  - (csl_pkg::IQ_PTR_BITS + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/core/csl_scan.sv
// back end: scanner state machine with line and column tracking
`include "c_subset_lexer_core_macros.svh"

module csl_scan (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  csl_pkg::item_type    item,
   input  logic                 space_ok,
   output logic                 pop,
   output csl_pkg::push_type    push
);

   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_INT,
      MODE_FRAC,
      MODE_EXP_SIGN,
      MODE_EXP_DIGITS,
      MODE_STRING,
      MODE_ESCAPE,
      MODE_UNKNOWN
   } scan_mode_type;

   localparam logic [csl_pkg::LINE_BITS-1:0]   LINE_MAX  = '1;
   localparam logic [csl_pkg::COLUMN_BITS-1:0] COL_MAX   = '1;
   localparam logic [csl_pkg::LINE_BITS-1:0]   LINE_FIRST = csl_pkg::LINE_BITS'(1);
   localparam logic [csl_pkg::WLEN_BITS-1:0]   WLEN_MAX  =
      csl_pkg::WLEN_BITS'(csl_pkg::KEYWORD_MAX_LEN);

   scan_mode_type                          mode_ff, mode_in;
   logic [csl_pkg::LINE_BITS-1:0]          line_ff, line_in;
   logic [csl_pkg::COLUMN_BITS-1:0]        col_ff, col_in;
   logic [csl_pkg::LINE_BITS-1:0]          sline_ff, sline_in;
   logic [csl_pkg::COLUMN_BITS-1:0]        scol_ff, scol_in;
   csl_pkg::word_type                      chars_ff, chars_in;
   logic [csl_pkg::WLEN_BITS-1:0]          wlen_ff, wlen_in;
   logic                                   digits_ff, digits_in;

   logic                                   fire;
   logic                                   is_space, is_word, is_ident_start;
   logic                                   is_sign;
   logic                                   close_vld, tail_vld;
   logic [csl_pkg::KIND_BITS-1:0]          close_kind, tail_kind;
   logic                                   redo_idle, redo_unknown;
   csl_pkg::token_type                     close_tok, tail_tok;

   assign fire = !q_empty && space_ok;
   assign pop  = fire;

   // character groups
   assign is_space = item.cls inside {csl_pkg::CC_LF, csl_pkg::CC_CR, csl_pkg::CC_SPACE};
   assign is_ident_start = item.cls inside {csl_pkg::CC_LETTER_E, csl_pkg::CC_LETTER_F,
                                            csl_pkg::CC_WORD};
   assign is_word  = is_ident_start || (item.cls == csl_pkg::CC_DIGIT);
   assign is_sign  = (item.cls == csl_pkg::CC_OP) &&
                     ((item.op_idx == csl_pkg::OP_PLUS) || (item.op_idx == csl_pkg::OP_MINUS));

   // next state and emitted tokens for the item at the queue head
   always_comb begin
      mode_in      = mode_ff;
      line_in      = line_ff;
      col_in       = col_ff;
      sline_in     = sline_ff;
      scol_in      = scol_ff;
      chars_in     = chars_ff;
      wlen_in      = wlen_ff;
      digits_in    = digits_ff;
      close_vld    = 1'b0;
      close_kind   = csl_pkg::KIND_UNKNOWN;
      tail_vld     = 1'b0;
      tail_kind    = csl_pkg::KIND_END;
      redo_idle    = 1'b0;
      redo_unknown = 1'b0;

      if (item.eot) begin
         // close whatever is pending, then the end token and a full restart
         case (mode_ff)
            MODE_IDLE: begin
               close_vld = 1'b0;
            end
            MODE_IDENT: begin
               close_vld  = 1'b1;
               close_kind = csl_pkg::keyword_kind(chars_ff, wlen_ff);
            end
            MODE_INT: begin
               close_vld  = 1'b1;
               close_kind = csl_pkg::KIND_INT;
            end
            MODE_FRAC, MODE_EXP_DIGITS: begin
               close_vld  = 1'b1;
               close_kind = digits_ff ? csl_pkg::KIND_DOUBLE : csl_pkg::KIND_UNKNOWN;
            end
            default: begin
               close_vld  = 1'b1;
               close_kind = csl_pkg::KIND_UNKNOWN;
            end
         endcase
         tail_vld  = 1'b1;
         tail_kind = csl_pkg::KIND_END;
         mode_in   = MODE_IDLE;
         line_in   = LINE_FIRST;
         col_in    = '0;
         sline_in  = LINE_FIRST;
         scol_in   = '0;
         wlen_in   = '0;
         digits_in = 1'b0;
      end else begin
         // position: newline resets the column, any other byte advances it
         if (item.cls == csl_pkg::CC_LF) begin
            if (line_ff != LINE_MAX) begin
               line_in = line_ff + 1'b1;
            end
            col_in = '0;
         end else if (col_ff != COL_MAX) begin
            col_in = col_ff + 1'b1;
         end

         // current mode
         case (mode_ff)
            MODE_IDENT: begin
               if (is_word) begin
                  if (wlen_ff < WLEN_MAX) begin
                     chars_in[wlen_ff[csl_pkg::WIDX_BITS-1:0]] = item.code;
                  end
                  if (wlen_ff <= WLEN_MAX) begin
                     wlen_in = wlen_ff + 1'b1;
                  end
               end else begin
                  close_vld  = 1'b1;
                  close_kind = csl_pkg::keyword_kind(chars_ff, wlen_ff);
                  redo_idle  = 1'b1;
               end
            end
            MODE_INT: begin
               if (item.cls == csl_pkg::CC_DOT) begin
                  digits_in = 1'b0;
                  mode_in   = MODE_FRAC;
               end else if (item.cls == csl_pkg::CC_LETTER_E) begin
                  mode_in = MODE_EXP_SIGN;
               end else if (item.cls != csl_pkg::CC_DIGIT) begin
                  close_vld  = 1'b1;
                  close_kind = csl_pkg::KIND_INT;
                  redo_idle  = 1'b1;
               end
            end
            MODE_FRAC: begin
               if (item.cls == csl_pkg::CC_DIGIT) begin
                  digits_in = 1'b1;
               end else if (!digits_ff || (item.cls == csl_pkg::CC_DOT)) begin
                  redo_unknown = 1'b1;
               end else if (item.cls == csl_pkg::CC_LETTER_E) begin
                  mode_in = MODE_EXP_SIGN;
               end else if (item.cls == csl_pkg::CC_LETTER_F) begin
                  close_vld  = 1'b1;
                  close_kind = csl_pkg::KIND_FLOAT;
                  mode_in    = MODE_IDLE;
               end else begin
                  close_vld  = 1'b1;
                  close_kind = csl_pkg::KIND_DOUBLE;
                  redo_idle  = 1'b1;
               end
            end
            MODE_EXP_SIGN: begin
               // sign is optional: anything else is an exponent digit or a fault
               digits_in = 1'b0;
               mode_in   = MODE_EXP_DIGITS;
               if (!is_sign) begin
                  if (item.cls == csl_pkg::CC_DIGIT) begin
                     digits_in = 1'b1;
                  end else begin
                     redo_unknown = 1'b1;
                  end
               end
            end
            MODE_EXP_DIGITS: begin
               if (item.cls == csl_pkg::CC_DIGIT) begin
                  digits_in = 1'b1;
               end else if (!digits_ff) begin
                  redo_unknown = 1'b1;
               end else if (item.cls == csl_pkg::CC_LETTER_F) begin
                  close_vld  = 1'b1;
                  close_kind = csl_pkg::KIND_FLOAT;
                  mode_in    = MODE_IDLE;
               end else begin
                  close_vld  = 1'b1;
                  close_kind = csl_pkg::KIND_DOUBLE;
                  redo_idle  = 1'b1;
               end
            end
            MODE_STRING: begin
               if ((item.cls == csl_pkg::CC_QUOTE) || (item.cls == csl_pkg::CC_LF)) begin
                  close_vld  = 1'b1;
                  close_kind = csl_pkg::KIND_STRING;
                  mode_in    = MODE_IDLE;
               end else if (item.cls == csl_pkg::CC_BSLASH) begin
                  mode_in = MODE_ESCAPE;
               end
            end
            MODE_ESCAPE: begin
               if (item.cls != csl_pkg::CC_CR) begin
                  mode_in = MODE_STRING;
               end
            end
            MODE_UNKNOWN: begin
               redo_unknown = 1'b1;
            end
            default: begin
               redo_idle = 1'b1;
            end
         endcase

         // unknown run lasts up to the next whitespace byte
         if (redo_unknown) begin
            if (is_space) begin
               close_vld  = 1'b1;
               close_kind = csl_pkg::KIND_UNKNOWN;
               redo_idle  = 1'b1;
            end else begin
               mode_in = MODE_UNKNOWN;
            end
         end

         // byte between tokens, possibly the one that closed the last token
         if (redo_idle) begin
            mode_in = MODE_IDLE;
            if ((item.cls != csl_pkg::CC_CR) && (item.cls != csl_pkg::CC_LF)) begin
               sline_in = line_ff;
               scol_in  = col_ff;
               if (item.cls == csl_pkg::CC_QUOTE) begin
                  mode_in = MODE_STRING;
               end else if (is_ident_start) begin
                  chars_in[0] = item.code;
                  wlen_in     = csl_pkg::WLEN_BITS'(1);
                  mode_in     = MODE_IDENT;
               end else if (item.cls == csl_pkg::CC_DIGIT) begin
                  mode_in = MODE_INT;
               end else if (item.cls == csl_pkg::CC_OP) begin
                  tail_vld  = 1'b1;
                  tail_kind = csl_pkg::KIND_BITS'(item.op_idx);
               end else if (item.cls != csl_pkg::CC_SPACE) begin
                  mode_in = MODE_UNKNOWN;
               end
            end
         end
      end
   end

   // token assembly: closing token at its start, second token at this byte
   always_comb begin
      close_tok.kind   = close_kind;
      close_tok.line   = sline_ff;
      close_tok.column = scol_ff;
      close_tok.last   = !tail_vld;
      tail_tok.kind    = tail_kind;
      tail_tok.line    = line_ff;
      tail_tok.column  = col_ff;
      tail_tok.last    = 1'b1;

      push.tok0  = close_vld ? close_tok : tail_tok;
      push.tok1  = tail_tok;
      push.count = fire ? (2'(close_vld) + 2'(tail_vld)) : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         line_ff   <= LINE_FIRST;
         col_ff    <= '0;
         sline_ff  <= LINE_FIRST;
         scol_ff   <= '0;
         wlen_ff   <= '0;
         digits_ff <= 1'b0;
      end else if (fire) begin
         mode_ff   <= mode_in;
         line_ff   <= line_in;
         col_ff    <= col_in;
         sline_ff  <= sline_in;
         scol_ff   <= scol_in;
         wlen_ff   <= wlen_in;
         digits_ff <= digits_in;
      end
   end

   // word buffer
   always_ff @(posedge clock) begin
      if (fire) begin
         chars_ff <= chars_in;
      end
   end

   `CSL_ASSERT_NEXT(a_eot_restarts, fire && item.eot, mode_ff == MODE_IDLE && line_ff == LINE_FIRST && col_ff == '0, "end of text did not restart the scanner")
   `CSL_ASSERT_NEXT(a_lf_column, fire && !item.eot && item.cls == csl_pkg::CC_LF, col_ff == '0, "newline did not clear the column")
   `CSL_ASSERT_NOW(a_pair_tail, push.count == 2'd2, push.tok1.kind < csl_pkg::KIND_BITS'(csl_pkg::OP_COUNT) || push.tok1.kind == csl_pkg::KIND_END, "two tokens but the second is neither operator nor end")

endmodule

// File: rtl/core/csl_outq.sv
// output token queue that serializes scanner tokens onto the response channel
`include "c_subset_lexer_core_macros.svh"

module csl_outq (
   input  logic                 clock,
   input  logic                 reset,
   input  csl_pkg::push_type    push,
   output logic                 space_ok,
   csl_rsp_if.source            rsp_if
);

   localparam int CNT_BITS = csl_pkg::OUTQ_PTR_BITS + 1;

   csl_pkg::token_type                   mem [csl_pkg::OUTQ_DEPTH];
   logic [csl_pkg::OUTQ_PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [csl_pkg::OUTQ_PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]                  count_ff, count_in;
   logic                                 pop;
   csl_pkg::token_type                   head;

   // room for a full pair of tokens from the scanner
   assign space_ok = (count_ff <= CNT_BITS'(csl_pkg::OUTQ_DEPTH - 2));

   // response channel driven from the queue head
   assign head                = mem[rd_ptr_ff];
   assign rsp_if.valid        = (count_ff != '0);
   assign rsp_if.token_kind   = head.kind;
   assign rsp_if.token_line   = head.line;
   assign rsp_if.token_column = head.column;
   assign rsp_if.last_of_run  = head.last;
   assign pop                 = rsp_if.valid && rsp_if.ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + csl_pkg::OUTQ_PTR_BITS'(push.count);
      rd_ptr_in = rd_ptr_ff + csl_pkg::OUTQ_PTR_BITS'(pop);
      count_in  = count_ff + CNT_BITS'(push.count) - CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, two writes when a transfer closes one token and opens another
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ptr_ff] <= push.tok0;
      end
      if (push.count == 2'd2) begin
         mem[wr_ptr_ff + csl_pkg::OUTQ_PTR_BITS'(1)] <= push.tok1;
      end
   end

   `CSL_ASSERT_NOW(a_push_has_room, push.count != 2'd0, space_ok, "tokens pushed without room")
   `CSL_ASSERT_NEXT(a_pop_only, pop && push.count == 2'd0, count_ff == $past(count_ff) - 1'b1, "fill count wrong after a lone transfer")

endmodule

// File: rtl/core/c_subset_lexer_core.sv
// Lexer core for a C subset: source bytes in, tokens with kind, line and column out.
//
// req_if takes one item per transfer: command 0 carries a source byte in char_code,
// command 1 marks end of text. rsp_if gives one token per transfer with its kind,
// the line and column where it starts, and last_of_run on the final token that an
// item caused. An item may cause no token, one, or two (a closed token followed by
// an operator or by the end token); end of text also restarts line and column.
// Throughput is one byte per clock while each byte causes at most one token and the
// receiver keeps up; a byte causing two tokens needs two response transfers.
// Bytes pass through the registered item queue and tokens through the token queue.
// A four-entry item queue parts the front end from the scanner, and a four-entry
// token queue parts the scanner from the receiver; the scanner handles a byte only
// when two token slots are free. When the receiver stalls, tokens collect there and
// then the item queue fills, and req_if.ready drops once it holds four items.
// Reset is synchronous: both queues empty, scanning restarts at line 1, column 0.
module c_subset_lexer_core (
   input  logic        clock,
   input  logic        reset,
   csl_req_if.sink     req_if,
   csl_rsp_if.source   rsp_if
);

   logic                 q_push_valid;
   csl_pkg::item_type    q_push_item;
   logic                 q_full;
   logic                 q_empty;
   logic                 q_pop;
   csl_pkg::item_type    q_head;
   logic                 outq_space_ok;
   csl_pkg::push_type    tok_push;

   // byte classification and request handshake
   csl_front u_front (
      .req_if     (req_if),
      .q_full     (q_full),
      .push_valid (q_push_valid),
      .push_item  (q_push_item)
   );

   // classified items waiting for the scanner
   csl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_item  (q_push_item),
      .pop        (q_pop),
      .full       (q_full),
      .empty      (q_empty),
      .head       (q_head)
   );

   // scanner state machine
   csl_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .item     (q_head),
      .space_ok (outq_space_ok),
      .pop      (q_pop),
      .push     (tok_push)
   );

   // token queue and response handshake
   csl_outq u_outq (
      .clock    (clock),
      .reset    (reset),
      .push     (tok_push),
      .space_ok (outq_space_ok),
      .rsp_if   (rsp_if)
   );

endmodule
